@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros, all clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge out of reset.
`define CIA_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Condition that must hold in the cycle after the trigger.
`define CIA_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) else $error(msg);

`endif

@@ rtl/core/cia_pkg.sv @@
// ----------------------------------------------------------------------------
// cia_pkg
// Types, register map and bit positions of the interface adapter.
// ----------------------------------------------------------------------------
package cia_pkg;

  // Item commands
  typedef enum logic [2:0] {
    CMD_READ  = 3'd0,
    CMD_WRITE = 3'd1,
    CMD_ECLK  = 3'd2,
    CMD_TOD   = 3'd3,
    CMD_FLAG  = 3'd4
  } cia_cmd_t;

  // Register map
  localparam logic [3:0] REG_PRA  = 4'h0;
  localparam logic [3:0] REG_PRB  = 4'h1;
  localparam logic [3:0] REG_DDRA = 4'h2;
  localparam logic [3:0] REG_DDRB = 4'h3;
  localparam logic [3:0] REG_TALO = 4'h4;
  localparam logic [3:0] REG_TAHI = 4'h5;
  localparam logic [3:0] REG_TBLO = 4'h6;
  localparam logic [3:0] REG_TBHI = 4'h7;
  localparam logic [3:0] REG_TOD0 = 4'h8;
  localparam logic [3:0] REG_TOD1 = 4'h9;
  localparam logic [3:0] REG_TOD2 = 4'hA;
  localparam logic [3:0] REG_SDR  = 4'hC;
  localparam logic [3:0] REG_ICR  = 4'hD;
  localparam logic [3:0] REG_CRA  = 4'hE;
  localparam logic [3:0] REG_CRB  = 4'hF;

  // Widths
  localparam int unsigned TIMER_W = 16;
  localparam int unsigned TOD_W   = 24;
  localparam int unsigned SRC_W   = 5;

  localparam logic [TIMER_W-1:0] TIMER_RESET = 16'hFFFF;

  // Control register bits
  localparam int unsigned CR_START    = 0;
  localparam int unsigned CR_ONE_SHOT = 3;
  localparam int unsigned CR_CASCADE  = 6;
  localparam logic [7:0] CR_STORE_MASK = 8'hEF;  // force-load bit is not kept
  localparam int unsigned CR_FORCE_LOAD = 4;

  // Interrupt flag bits
  localparam int unsigned FLG_TA   = 0;
  localparam int unsigned FLG_TB   = 1;
  localparam int unsigned FLG_SP   = 3;
  localparam int unsigned FLG_FLAG = 4;
  localparam int unsigned ICR_SET  = 7;

  // One result item
  typedef struct packed {
    logic [7:0] rdata;
    logic       irq;
    logic [7:0] port_a_drive;
    logic [7:0] port_b_drive;
  } cia_res_t;

endpackage

@@ rtl/core/cia_cmd_if.sv @@
// ----------------------------------------------------------------------------
// cia_cmd_if
// Valid/ready channel carrying one command item into the adapter.
// ----------------------------------------------------------------------------
interface cia_cmd_if;
  logic       valid;
  logic       ready;
  logic [2:0] cmd;
  logic [3:0] reg_addr;
  logic [7:0] wdata;
  logic [7:0] port_a_pins;
  logic [7:0] port_b_pins;

  modport source (output valid, output cmd, output reg_addr, output wdata,
                  output port_a_pins, output port_b_pins, input ready);
  modport sink   (input valid, input cmd, input reg_addr, input wdata,
                  input port_a_pins, input port_b_pins, output ready);
endinterface

@@ rtl/core/cia_res_if.sv @@
// ----------------------------------------------------------------------------
// cia_res_if
// Valid/ready channel carrying one result item out of the adapter.
// ----------------------------------------------------------------------------
interface cia_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] rdata;
  logic       irq;
  logic [7:0] port_a_drive;
  logic [7:0] port_b_drive;

  modport source (output valid, output rdata, output irq, output port_a_drive,
                  output port_b_drive, input ready);
  modport sink   (input valid, input rdata, input irq, input port_a_drive,
                  input port_b_drive, output ready);
endinterface

@@ rtl/core/cia_ports_timers_interrupts_unit.sv @@
// ----------------------------------------------------------------------------
// cia_ports_timers_interrupts_unit
// Ports, two interval timers, time-of-day counter and interrupt control.
// ----------------------------------------------------------------------------
//  Channel   Dir  Payload                                    Handshake
//  cmd_ch    in   cmd, reg_addr, wdata, port_a/b_pins        valid/ready
//  res_ch    out  rdata, irq, port_a_drive, port_b_drive     valid/ready
//
// One item per cycle: the state update for an item is a single combinational
// pass at the transfer, and its result lands in a two-entry output queue.
// With an empty queue, res_ch.valid rises in the cycle after the transfer.
// cmd_ch.ready drops only while both queue entries hold untaken results.
// rst is synchronous; registers other than res_q take their reset values.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cia_ports_timers_interrupts_unit (
  input  logic      clk,
  input  logic      rst,
  cia_cmd_if.sink   cmd_ch,
  cia_res_if.source res_ch
);
  import cia_pkg::*;

  // Architectural state
  logic [7:0]         port_a_data, port_b_data, port_a_dir, port_b_dir;
  logic [TIMER_W-1:0] timer_a_count, timer_b_count, timer_a_reload, timer_b_reload;
  logic [TOD_W-1:0]   tod_count;
  logic [7:0]         serial_data, ctrl_a, ctrl_b;
  logic [SRC_W-1:0]   int_flags, int_mask;

  logic [7:0]         port_a_data_next, port_b_data_next, port_a_dir_next, port_b_dir_next;
  logic [TIMER_W-1:0] timer_a_count_next, timer_b_count_next;
  logic [TIMER_W-1:0] timer_a_reload_next, timer_b_reload_next;
  logic [TOD_W-1:0]   tod_count_next;
  logic [7:0]         serial_data_next, ctrl_a_next, ctrl_b_next;
  logic [SRC_W-1:0]   int_flags_next, int_mask_next;

  logic       in_fire, out_fire;
  logic       irq_now, b_tick;
  logic [7:0] rd_val;
  cia_res_t   res_new;

  // Result queue
  cia_res_t   res_q [2];
  logic [1:0] fill;

  assign in_fire  = cmd_ch.valid & cmd_ch.ready;
  assign out_fire = res_ch.valid & res_ch.ready;
  assign irq_now  = |(int_flags & int_mask);

  // Next state for the accepted item
  always_comb begin
    port_a_data_next    = port_a_data;
    port_b_data_next    = port_b_data;
    port_a_dir_next     = port_a_dir;
    port_b_dir_next     = port_b_dir;
    timer_a_count_next  = timer_a_count;
    timer_b_count_next  = timer_b_count;
    timer_a_reload_next = timer_a_reload;
    timer_b_reload_next = timer_b_reload;
    tod_count_next      = tod_count;
    serial_data_next    = serial_data;
    ctrl_a_next         = ctrl_a;
    ctrl_b_next         = ctrl_b;
    int_flags_next      = int_flags;
    int_mask_next       = int_mask;
    rd_val              = 8'h00;
    b_tick              = 1'b0;

    if (in_fire) begin
      case (cia_cmd_t'(cmd_ch.cmd))
        CMD_READ: begin
          case (cmd_ch.reg_addr)
            REG_PRA:  rd_val = (port_a_data & port_a_dir) | (cmd_ch.port_a_pins & ~port_a_dir);
            REG_PRB:  rd_val = (port_b_data & port_b_dir) | (cmd_ch.port_b_pins & ~port_b_dir);
            REG_DDRA: rd_val = port_a_dir;
            REG_DDRB: rd_val = port_b_dir;
            REG_TALO: rd_val = timer_a_count[7:0];
            REG_TAHI: rd_val = timer_a_count[15:8];
            REG_TBLO: rd_val = timer_b_count[7:0];
            REG_TBHI: rd_val = timer_b_count[15:8];
            REG_TOD0: rd_val = tod_count[7:0];
            REG_TOD1: rd_val = tod_count[15:8];
            REG_TOD2: rd_val = tod_count[23:16];
            REG_SDR:  rd_val = serial_data;
            REG_ICR: begin
              // summary bit on top, cleared by the read
              rd_val         = {irq_now, 2'b00, int_flags};
              int_flags_next = '0;
            end
            REG_CRA:  rd_val = ctrl_a;
            REG_CRB:  rd_val = ctrl_b;
            default:  rd_val = 8'h00;
          endcase
        end
        CMD_WRITE: begin
          case (cmd_ch.reg_addr)
            REG_PRA:  port_a_data_next = cmd_ch.wdata;
            REG_PRB:  port_b_data_next = cmd_ch.wdata;
            REG_DDRA: port_a_dir_next  = cmd_ch.wdata;
            REG_DDRB: port_b_dir_next  = cmd_ch.wdata;
            REG_TALO: timer_a_reload_next = {timer_a_reload[15:8], cmd_ch.wdata};
            REG_TAHI: begin
              timer_a_reload_next = {cmd_ch.wdata, timer_a_reload[7:0]};
              if (!ctrl_a[CR_START]) timer_a_count_next = {cmd_ch.wdata, timer_a_reload[7:0]};
            end
            REG_TBLO: timer_b_reload_next = {timer_b_reload[15:8], cmd_ch.wdata};
            REG_TBHI: begin
              timer_b_reload_next = {cmd_ch.wdata, timer_b_reload[7:0]};
              if (!ctrl_b[CR_START]) timer_b_count_next = {cmd_ch.wdata, timer_b_reload[7:0]};
            end
            REG_TOD0: tod_count_next = {tod_count[23:8], cmd_ch.wdata};
            REG_TOD1: tod_count_next = {tod_count[23:16], cmd_ch.wdata, tod_count[7:0]};
            REG_TOD2: tod_count_next = {cmd_ch.wdata, tod_count[15:0]};
            REG_SDR: begin
              serial_data_next         = cmd_ch.wdata;
              int_flags_next[FLG_SP]   = 1'b1;
            end
            REG_ICR: begin
              // set/clear mask write
              if (cmd_ch.wdata[ICR_SET]) int_mask_next = int_mask | cmd_ch.wdata[SRC_W-1:0];
              else                       int_mask_next = int_mask & ~cmd_ch.wdata[SRC_W-1:0];
            end
            REG_CRA: begin
              ctrl_a_next = cmd_ch.wdata & CR_STORE_MASK;
              if (cmd_ch.wdata[CR_FORCE_LOAD]) timer_a_count_next = timer_a_reload;
            end
            REG_CRB: begin
              ctrl_b_next = cmd_ch.wdata & CR_STORE_MASK;
              if (cmd_ch.wdata[CR_FORCE_LOAD]) timer_b_count_next = timer_b_reload;
            end
            default: ;
          endcase
        end
        CMD_ECLK: begin
          // timer A
          if (ctrl_a[CR_START]) begin
            if (timer_a_count == '0) begin
              timer_a_count_next     = timer_a_reload;
              int_flags_next[FLG_TA] = 1'b1;
              if (ctrl_a[CR_ONE_SHOT]) ctrl_a_next[CR_START] = 1'b0;
              if (ctrl_b[CR_START] && ctrl_b[CR_CASCADE]) b_tick = 1'b1;
            end else begin
              timer_a_count_next = timer_a_count - 1'b1;
            end
          end
          // timer B on E-clock when not cascaded
          if (ctrl_b[CR_START] && !ctrl_b[CR_CASCADE]) b_tick = 1'b1;
          if (b_tick) begin
            if (timer_b_count == '0) begin
              timer_b_count_next     = timer_b_reload;
              int_flags_next[FLG_TB] = 1'b1;
              if (ctrl_b[CR_ONE_SHOT]) ctrl_b_next[CR_START] = 1'b0;
            end else begin
              timer_b_count_next = timer_b_count - 1'b1;
            end
          end
        end
        CMD_TOD:  tod_count_next = tod_count + 1'b1;
        CMD_FLAG: int_flags_next[FLG_FLAG] = 1'b1;
        default: ;
      endcase
    end
  end

  assign res_new.rdata        = rd_val;
  assign res_new.irq          = |(int_flags_next & int_mask_next);
  assign res_new.port_a_drive = port_a_data_next | ~port_a_dir_next;
  assign res_new.port_b_drive = port_b_data_next | ~port_b_dir_next;

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      port_a_data    <= '0;
      port_b_data    <= '0;
      port_a_dir     <= '0;
      port_b_dir     <= '0;
      timer_a_count  <= TIMER_RESET;
      timer_b_count  <= TIMER_RESET;
      timer_a_reload <= TIMER_RESET;
      timer_b_reload <= TIMER_RESET;
      tod_count      <= '0;
      serial_data    <= '0;
      ctrl_a         <= '0;
      ctrl_b         <= '0;
      int_flags      <= '0;
      int_mask       <= '0;
    end else begin
      port_a_data    <= port_a_data_next;
      port_b_data    <= port_b_data_next;
      port_a_dir     <= port_a_dir_next;
      port_b_dir     <= port_b_dir_next;
      timer_a_count  <= timer_a_count_next;
      timer_b_count  <= timer_b_count_next;
      timer_a_reload <= timer_a_reload_next;
      timer_b_reload <= timer_b_reload_next;
      tod_count      <= tod_count_next;
      serial_data    <= serial_data_next;
      ctrl_a         <= ctrl_a_next;
      ctrl_b         <= ctrl_b_next;
      int_flags      <= int_flags_next;
      int_mask       <= int_mask_next;
    end
  end

  // Output queue: entry 0 is the head
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= 2'd0;
    end else begin
      case ({in_fire, out_fire})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case ({in_fire, out_fire})
      2'b10: res_q[fill[0]] <= res_new;
      2'b01: res_q[0] <= res_q[1];
      2'b11: begin
        if (fill[1]) begin
          res_q[0] <= res_q[1];
          res_q[1] <= res_new;
        end else begin
          res_q[0] <= res_new;
        end
      end
      default: ;
    endcase
  end

  assign cmd_ch.ready        = ~fill[1];
  assign res_ch.valid        = (fill != 2'd0);
  assign res_ch.rdata        = res_q[0].rdata;
  assign res_ch.irq          = res_q[0].irq;
  assign res_ch.port_a_drive = res_q[0].port_a_drive;
  assign res_ch.port_b_drive = res_q[0].port_b_drive;

  // Checks
  `CIA_ASSERT_ALWAYS(a_fill_range, fill != 2'd3, "queue fill out of range")
  `CIA_ASSERT_NEXT(a_icr_clear, in_fire && cmd_ch.cmd == CMD_READ && cmd_ch.reg_addr == REG_ICR,
    int_flags == '0, "interrupt flags not cleared by read")
  `CIA_ASSERT_NEXT(a_idle_hold, !in_fire,
    $stable(timer_a_count) && $stable(timer_b_count) && $stable(tod_count) && $stable(int_flags),
    "state changed without an item")
  `CIA_ASSERT_NEXT(a_fill_up, in_fire && !out_fire, fill == $past(fill) + 2'd1,
    "result lost in output queue")

endmodule
